/* hdl/acp_pkg.sv */
`timescale 1ns / 1ps

package acp_pkg;

  localparam int MAX_ARGS   = 10;
  localparam int ARG_IDX_W  = $clog2(MAX_ARGS);
  localparam int ARG_CNT_W  = $clog2(MAX_ARGS + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  localparam logic [3:0] DEFAULT_FG_RESET = 4'd7;
  localparam logic [3:0] DEFAULT_BG_RESET = 4'd0;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  // Byte codes.
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] FIN_UP      = 8'h41;
  localparam logic [7:0] FIN_DOWN    = 8'h42;
  localparam logic [7:0] FIN_RIGHT   = 8'h43;
  localparam logic [7:0] FIN_LEFT    = 8'h44;
  localparam logic [7:0] FIN_NEXT    = 8'h45;
  localparam logic [7:0] FIN_PREV    = 8'h46;
  localparam logic [7:0] FIN_COLUMN  = 8'h47;
  localparam logic [7:0] FIN_POS     = 8'h48;
  localparam logic [7:0] FIN_POS_ALT = 8'h66;
  localparam logic [7:0] FIN_ERASE_S = 8'h4a;
  localparam logic [7:0] FIN_ERASE_L = 8'h4b;
  localparam logic [7:0] FIN_SCR_UP  = 8'h53;
  localparam logic [7:0] FIN_SCR_DN  = 8'h54;
  localparam logic [7:0] FIN_SAVE    = 8'h73;
  localparam logic [7:0] FIN_RESTORE = 8'h75;
  localparam logic [7:0] FIN_SGR     = 8'h6d;

  // SGR codes.
  localparam logic [15:0] SGR_RESET    = 16'd0;
  localparam logic [15:0] SGR_BOLD     = 16'd1;
  localparam logic [15:0] SGR_NO_BOLD  = 16'd22;
  localparam logic [15:0] SGR_FG_FIRST = 16'd30;
  localparam logic [15:0] SGR_FG_LAST  = 16'd37;
  localparam logic [15:0] SGR_FG_DEF   = 16'd39;
  localparam logic [15:0] SGR_BG_FIRST = 16'd40;
  localparam logic [15:0] SGR_BG_LAST  = 16'd47;
  localparam logic [15:0] SGR_BG_DEF   = 16'd49;

  localparam logic [3:0] BOLD_OFFSET = 4'd8;

  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_BOTH     = 2'd2;

  typedef enum logic [2:0] {
    ST_PLAIN,
    ST_ESC,
    ST_CSI,
    ST_NUM,
    ST_SGR
  } front_state_t;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR     = 3'd0,
    CMD_SET_CURSOR   = 3'd1,
    CMD_ERASE_SCREEN = 3'd2,
    CMD_ERASE_LINE   = 3'd3,
    CMD_SCROLL_UP    = 3'd4,
    CMD_SCROLL_DOWN  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    OP_PUT,
    OP_UP,
    OP_DOWN,
    OP_RIGHT,
    OP_LEFT,
    OP_NEXT_LINE,
    OP_PREV_LINE,
    OP_COLUMN,
    OP_POS_ROW,
    OP_POS_XY,
    OP_ERASE_SCREEN,
    OP_ERASE_LINE,
    OP_SCROLL_UP,
    OP_SCROLL_DOWN,
    OP_RESTORE
  } op_kind_t;

  // Stored argument: bit 16 marks an empty argument.
  typedef logic [16:0] arg_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  char_code;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] delta;
    logic [15:0] arg1;
    logic [1:0]  dir;
  } acp_op_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] amount;
    logic [1:0]  direction;
    logic [15:0] new_y;
    logic [15:0] new_x;
    logic [3:0]  bg_color;
    logic [3:0]  fg_color;
    logic [7:0]  char_code;
    cmd_t        command;
  } acp_result_t;

endpackage

/* hdl/acp_front.sv */
`timescale 1ns / 1ps

module acp_front
  import acp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [3:0]           cfg_data,
  output logic                 q_push,
  output acp_op_t              q_op,
  input  logic                 q_full
);

  front_state_t state, state_next;

  logic [3:0] default_fg, default_bg;
  logic [3:0] cur_fg, cur_fg_next;
  logic [3:0] cur_bg, cur_bg_next;
  logic       bold, bold_next;
  logic [15:0] saved_x, saved_x_next;
  logic [15:0] saved_y, saved_y_next;
  logic [15:0] accum, accum_next;
  logic [ARG_CNT_W-1:0] arg_count, arg_count_next;
  logic [ARG_IDX_W-1:0] sgr_idx, sgr_idx_next;
  arg_t arg_store [MAX_ARGS];
  logic arg_we;

  logic [7:0]  ch;
  logic [15:0] cx, cy;
  logic        accept, is_digit;
  arg_t        new_arg, arg0_eff, arg1_eff, sgr_arg;
  logic [15:0] delta;
  logic [19:0] accum_mul;
  logic        has_room;

  assign ch = s_tdata[7:0];
  assign cx = s_tdata[23:8];
  assign cy = s_tdata[39:24];

  assign s_tready = (state != ST_SGR) && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign has_room = arg_count < ARG_CNT_W'(MAX_ARGS);

  assign new_arg  = (state == ST_CSI) ? {1'b1, 16'd0} : {1'b0, accum};
  assign arg0_eff = (arg_count == '0) ? new_arg : arg_store[0];
  assign arg1_eff = (arg_count == ARG_CNT_W'(1)) ? new_arg : arg_store[1];
  assign delta    = (!arg0_eff[16] && arg0_eff[15:0] != 16'd0) ? arg0_eff[15:0] : 16'd1;
  assign accum_mul = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {12'd0, ch - CH_ZERO};
  assign sgr_arg  = arg_store[sgr_idx];

  always_comb begin
    state_next     = state;
    cur_fg_next    = cur_fg;
    cur_bg_next    = cur_bg;
    bold_next      = bold;
    saved_x_next   = saved_x;
    saved_y_next   = saved_y;
    accum_next     = accum;
    arg_count_next = arg_count;
    sgr_idx_next   = sgr_idx;
    arg_we         = 1'b0;
    q_push         = 1'b0;
    q_op           = '0;
    q_op.char_code = ch;
    q_op.x         = cx;
    q_op.y         = cy;
    q_op.delta     = delta;
    q_op.arg1      = arg1_eff[16] ? 16'd0 : arg1_eff[15:0];
    if (arg0_eff[16]) begin
      q_op.dir = DIR_BOTH;
    end else if (arg0_eff[15:0] == 16'd0) begin
      q_op.dir = DIR_FORWARD;
    end else if (arg0_eff[15:0] == 16'd1) begin
      q_op.dir = DIR_BACKWARD;
    end else begin
      q_op.dir = DIR_BOTH;
    end

    unique case (state)
      ST_PLAIN: begin
        if (accept) begin
          if (ch == CH_ESC) begin
            state_next = ST_ESC;
          end else begin
            q_push    = 1'b1;
            q_op.kind = OP_PUT;
            q_op.bg   = cur_bg;
            if (!bold) begin
              q_op.fg = cur_fg;
            end else if (cur_fg[3]) begin
              q_op.fg = 4'hf;
            end else begin
              q_op.fg = cur_fg | BOLD_OFFSET;
            end
          end
        end
      end
      ST_ESC: begin
        if (accept) begin
          if (ch == CH_LBRACKET) begin
            state_next     = ST_CSI;
            arg_count_next = '0;
            accum_next     = '0;
          end else begin
            state_next = ST_PLAIN;
          end
        end
      end
      ST_CSI, ST_NUM: begin
        if (accept) begin
          if (ch == CH_SEMI || !is_digit) begin
            arg_we     = 1'b1;
            accum_next = '0;
            if (has_room) begin
              arg_count_next = arg_count + ARG_CNT_W'(1);
            end
          end
          if (ch == CH_SEMI) begin
            state_next = ST_CSI;
          end else if (!is_digit) begin
            state_next = ST_PLAIN;
            q_push     = 1'b1;
            priority case (ch)
              FIN_UP: begin
                q_op.kind = OP_UP;
                q_push    = (cy != 16'd0);
              end
              FIN_DOWN:  q_op.kind = OP_DOWN;
              FIN_RIGHT: q_op.kind = OP_RIGHT;
              FIN_LEFT: begin
                q_op.kind = OP_LEFT;
                q_push    = (cx != 16'd0);
              end
              FIN_NEXT:   q_op.kind = OP_NEXT_LINE;
              FIN_PREV:   q_op.kind = OP_PREV_LINE;
              FIN_COLUMN: q_op.kind = OP_COLUMN;
              FIN_POS, FIN_POS_ALT: begin
                q_op.kind = (arg_count == '0) ? OP_POS_ROW : OP_POS_XY;
              end
              FIN_ERASE_S: q_op.kind = OP_ERASE_SCREEN;
              FIN_ERASE_L: q_op.kind = OP_ERASE_LINE;
              FIN_SCR_UP:  q_op.kind = OP_SCROLL_UP;
              FIN_SCR_DN:  q_op.kind = OP_SCROLL_DOWN;
              FIN_RESTORE: begin
                q_op.kind = OP_RESTORE;
                q_op.x    = saved_x;
                q_op.y    = saved_y;
              end
              FIN_SAVE: begin
                q_push       = 1'b0;
                saved_x_next = cx;
                saved_y_next = cy;
              end
              FIN_SGR: begin
                q_push       = 1'b0;
                state_next   = ST_SGR;
                sgr_idx_next = '0;
              end
              default: q_push = 1'b0;
            endcase
          end else begin
            state_next = ST_NUM;
            accum_next = (accum_mul > 20'hffff) ? 16'hffff : accum_mul[15:0];
          end
        end
      end
      ST_SGR: begin
        // One stored argument is applied per cycle, in order.
        if (!sgr_arg[16]) begin
          if (sgr_arg[15:0] == SGR_RESET) begin
            cur_fg_next = default_fg;
            cur_bg_next = default_bg;
            bold_next   = 1'b0;
          end else if (sgr_arg[15:0] == SGR_BOLD) begin
            bold_next = 1'b1;
          end else if (sgr_arg[15:0] == SGR_NO_BOLD) begin
            bold_next = 1'b0;
          end else if (sgr_arg[15:0] >= SGR_FG_FIRST && sgr_arg[15:0] <= SGR_FG_LAST) begin
            cur_fg_next = 4'(sgr_arg[15:0] - SGR_FG_FIRST);
          end else if (sgr_arg[15:0] == SGR_FG_DEF) begin
            cur_fg_next = default_fg;
          end else if (sgr_arg[15:0] >= SGR_BG_FIRST && sgr_arg[15:0] <= SGR_BG_LAST) begin
            cur_bg_next = 4'(sgr_arg[15:0] - SGR_BG_FIRST);
          end else if (sgr_arg[15:0] == SGR_BG_DEF) begin
            cur_bg_next = default_bg;
          end
        end
        if ((ARG_CNT_W'(sgr_idx) + ARG_CNT_W'(1)) == arg_count) begin
          state_next = ST_PLAIN;
        end else begin
          sgr_idx_next = sgr_idx + ARG_IDX_W'(1);
        end
      end
      default: state_next = ST_PLAIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_PLAIN;
      default_fg <= DEFAULT_FG_RESET;
      default_bg <= DEFAULT_BG_RESET;
      cur_fg     <= DEFAULT_FG_RESET;
      cur_bg     <= DEFAULT_BG_RESET;
      bold       <= 1'b0;
      saved_x    <= '0;
      saved_y    <= '0;
      accum      <= '0;
      arg_count  <= '0;
      sgr_idx    <= '0;
    end else begin
      state     <= state_next;
      cur_fg    <= cur_fg_next;
      cur_bg    <= cur_bg_next;
      bold      <= bold_next;
      saved_x   <= saved_x_next;
      saved_y   <= saved_y_next;
      accum     <= accum_next;
      arg_count <= arg_count_next;
      sgr_idx   <= sgr_idx_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_DEFAULT_FG) begin
          default_fg <= cfg_data;
        end else begin
          default_bg <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arg_we && has_room) begin
      arg_store[arg_count[ARG_IDX_W-1:0]] <= new_arg;
    end
  end

endmodule

/* hdl/acp_fifo.sv */
`timescale 1ns / 1ps

module acp_fifo
  import acp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  acp_op_t push_op,
  output logic    full,
  output logic    head_valid,
  output acp_op_t head_op,
  input  logic    pop
);

  acp_op_t entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic do_push, do_pop;

  assign full       = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (FIFO_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (FIFO_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

/* hdl/acp_back.sv */
`timescale 1ns / 1ps

module acp_back
  import acp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  input  acp_op_t               op,
  output logic                  op_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  acp_result_t res, res_next;
  logic [15:0] base;
  logic [16:0] sum;
  logic [15:0] sat_sum, sat_diff, delta_m1, arg1_m1;
  logic        horiz;

  assign op_pop = op_valid && (!m_tvalid || m_tready);

  // One shared saturating adder and subtractor; the operand is the column for
  // horizontal moves and the row otherwise (1 for a previous-line move from row 0).
  assign horiz = (op.kind == OP_RIGHT) || (op.kind == OP_LEFT);
  always_comb begin
    if (horiz) begin
      base = op.x;
    end else if (op.kind == OP_PREV_LINE && op.y == 16'd0) begin
      base = 16'd1;
    end else begin
      base = op.y;
    end
  end

  assign sum      = {1'b0, base} + {1'b0, op.delta};
  assign sat_sum  = sum[16] ? 16'hffff : sum[15:0];
  assign sat_diff = (base > op.delta) ? (base - op.delta) : 16'd0;
  assign delta_m1 = op.delta - 16'd1;
  assign arg1_m1  = (op.arg1 != 16'd0) ? (op.arg1 - 16'd1) : 16'd0;

  always_comb begin
    res_next         = '0;
    res_next.command = CMD_SET_CURSOR;
    unique case (op.kind)
      OP_PUT: begin
        res_next.command   = CMD_PUT_CHAR;
        res_next.char_code = op.char_code;
        res_next.fg_color  = op.fg;
        res_next.bg_color  = op.bg;
      end
      OP_UP: begin
        res_next.new_x = op.x;
        res_next.new_y = sat_diff;
      end
      OP_DOWN: begin
        res_next.new_x = op.x;
        res_next.new_y = sat_sum;
      end
      OP_RIGHT: begin
        res_next.new_x = sat_sum;
        res_next.new_y = op.y;
      end
      OP_LEFT: begin
        res_next.new_x = sat_diff;
        res_next.new_y = op.y;
      end
      OP_NEXT_LINE: res_next.new_y = sat_sum;
      OP_PREV_LINE: res_next.new_y = sat_diff;
      OP_COLUMN: begin
        res_next.new_x = delta_m1;
        res_next.new_y = op.y;
      end
      OP_POS_ROW: begin
        res_next.new_x = op.x;
        res_next.new_y = delta_m1;
      end
      OP_POS_XY: begin
        res_next.new_x = arg1_m1;
        res_next.new_y = delta_m1;
      end
      OP_ERASE_SCREEN: begin
        res_next.command   = CMD_ERASE_SCREEN;
        res_next.direction = op.dir;
      end
      OP_ERASE_LINE: begin
        res_next.command   = CMD_ERASE_LINE;
        res_next.direction = op.dir;
      end
      OP_SCROLL_UP: begin
        res_next.command = CMD_SCROLL_UP;
        res_next.amount  = op.delta;
      end
      OP_SCROLL_DOWN: begin
        res_next.command = CMD_SCROLL_DOWN;
        res_next.amount  = op.delta;
      end
      OP_RESTORE: begin
        res_next.new_x = op.x;
        res_next.new_y = op.y;
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      res <= res_next;
    end
  end

  assign m_tdata = res;

endmodule

/* hdl/ansi_csi_console_parser.sv */
`timescale 1ns / 1ps

// Console byte parser for ANSI CSI sequences. Each input item is one byte with
// the display's current cursor; each result item is one display command. The
// front end takes one byte per cycle while the queue is not full, except that
// an SGR final byte ('m') holds the input while the color walk runs over the
// argument registers. Decoded commands pass through a four-entry queue to the
// back end, which does the cursor arithmetic and registers the result; each
// command goes through its queue entry and then the result register.
// Configuration writes are always ready.
module ansi_csi_console_parser
  import acp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // byte_in [7:0], cursor_x [23:8], cursor_y [39:24]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // command [2:0], char_code [10:3], fg_color [14:11], bg_color [18:15],
  // new_x [34:19], new_y [50:35], direction [52:51], amount [68:53]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [3:0]            cfg_data
);

  logic    q_push, q_full, q_valid, q_pop;
  acp_op_t q_in, q_head;

  assign cfg_ready = 1'b1;

  acp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_op      (q_in),
    .q_full    (q_full)
  );

  acp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_in),
    .full       (q_full),
    .head_valid (q_valid),
    .head_op    (q_head),
    .pop        (q_pop)
  );

  acp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op       (q_head),
    .op_pop   (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* tb/sv/ansi_csi_console_parser_tb.sv */
`timescale 1ns / 1ps

module ansi_csi_console_parser_tb;
  import acp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 160;
  // A final byte that selects no command.
  localparam logic [7:0] FIN_UNUSED = 8'h7a;

  class console_cmd_model;
    logic [3:0]   dflt_fg;
    logic [3:0]   dflt_bg;
    logic [3:0]   fg;
    logic [3:0]   bg;
    bit           bold;
    front_state_t mode;
    int           args[MAX_ARGS];
    int           nargs;
    int           accum;
    logic [15:0]  saved_x;
    logic [15:0]  saved_y;
    acp_result_t  pending_cmds[$];
    int           errors;

    function new();
      dflt_fg = DEFAULT_FG_RESET;
      dflt_bg = DEFAULT_BG_RESET;
      fg      = DEFAULT_FG_RESET;
      bg      = DEFAULT_BG_RESET;
      bold    = 1'b0;
      mode    = ST_PLAIN;
      nargs   = 0;
      accum   = 0;
      saved_x = '0;
      saved_y = '0;
      errors  = 0;
    endfunction

    function void set_default(logic idx, logic [3:0] val);
      if (idx == CFG_DEFAULT_FG) begin
        dflt_fg = val;
      end else begin
        dflt_bg = val;
      end
    endfunction

    function int sat_add(int a, int b);
      return (a + b > 65535) ? 65535 : a + b;
    endfunction

    function int sat_sub(int a, int b);
      return (a > b) ? a - b : 0;
    endfunction

    // An argument ended before any digit arrived is stored as empty (-1).
    function void store_arg();
      if (nargs < MAX_ARGS) begin
        args[nargs] = (mode == ST_CSI) ? -1 : accum;
        nargs++;
      end
      accum = 0;
    endfunction

    function void expect_cursor(int x, int y);
      acp_result_t r;
      r = '0;
      r.command = CMD_SET_CURSOR;
      r.new_x = x[15:0];
      r.new_y = y[15:0];
      pending_cmds.push_back(r);
    endfunction

    function void apply_sgr();
      int a;
      for (int i = 0; i < nargs; i++) begin
        a = args[i];
        if (a == int'(SGR_RESET)) begin
          fg = dflt_fg;
          bg = dflt_bg;
          bold = 1'b0;
        end else if (a == int'(SGR_BOLD)) begin
          bold = 1'b1;
        end else if (a == int'(SGR_NO_BOLD)) begin
          bold = 1'b0;
        end else if (a >= int'(SGR_FG_FIRST) && a <= int'(SGR_FG_LAST)) begin
          fg = 4'(a - int'(SGR_FG_FIRST));
        end else if (a == int'(SGR_FG_DEF)) begin
          fg = dflt_fg;
        end else if (a >= int'(SGR_BG_FIRST) && a <= int'(SGR_BG_LAST)) begin
          bg = 4'(a - int'(SGR_BG_FIRST));
        end else if (a == int'(SGR_BG_DEF)) begin
          bg = dflt_bg;
        end
      end
    endfunction

    function void run_final(logic [7:0] c, int x, int y);
      int delta;
      int a;
      acp_result_t r;
      r = '0;
      delta = (nargs > 0 && args[0] > 0) ? args[0] : 1;
      case (c)
        FIN_UP: begin
          if (y != 0) expect_cursor(x, sat_sub(y, delta));
        end
        FIN_DOWN:   expect_cursor(x, sat_add(y, delta));
        FIN_RIGHT:  expect_cursor(sat_add(x, delta), y);
        FIN_LEFT: begin
          if (x != 0) expect_cursor(sat_sub(x, delta), y);
        end
        FIN_NEXT:   expect_cursor(0, sat_add(y, delta));
        FIN_PREV:   expect_cursor(0, sat_sub((y == 0) ? 1 : y, delta));
        FIN_COLUMN: expect_cursor(delta - 1, y);
        FIN_POS, FIN_POS_ALT: begin
          if (nargs <= 1) begin
            expect_cursor(x, delta - 1);
          end else begin
            a = args[1];
            expect_cursor((a > 0) ? a - 1 : 0, delta - 1);
          end
        end
        FIN_ERASE_S, FIN_ERASE_L: begin
          r.command = (c == FIN_ERASE_S) ? CMD_ERASE_SCREEN : CMD_ERASE_LINE;
          a = (nargs > 0) ? args[0] : 0;
          r.direction = (a == 0) ? DIR_FORWARD : (a == 1) ? DIR_BACKWARD : DIR_BOTH;
          pending_cmds.push_back(r);
        end
        FIN_SCR_UP, FIN_SCR_DN: begin
          r.command = (c == FIN_SCR_UP) ? CMD_SCROLL_UP : CMD_SCROLL_DOWN;
          r.amount = delta[15:0];
          pending_cmds.push_back(r);
        end
        FIN_SAVE: begin
          saved_x = x[15:0];
          saved_y = y[15:0];
        end
        FIN_RESTORE: expect_cursor(int'(saved_x), int'(saved_y));
        FIN_SGR:     apply_sgr();
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic [15:0] x, logic [15:0] y);
      acp_result_t r;
      int f;
      r = '0;
      case (mode)
        ST_PLAIN: begin
          if (c == CH_ESC) begin
            mode = ST_ESC;
          end else begin
            f = int'(fg) + (bold ? int'(BOLD_OFFSET) : 0);
            r.command = CMD_PUT_CHAR;
            r.char_code = c;
            r.fg_color = (f > 15) ? 4'hf : 4'(f);
            r.bg_color = bg;
            pending_cmds.push_back(r);
          end
        end
        ST_ESC: begin
          if (c == CH_LBRACKET) begin
            mode = ST_CSI;
            nargs = 0;
            accum = 0;
          end else begin
            mode = ST_PLAIN;
          end
        end
        default: begin
          if (c == CH_SEMI) begin
            store_arg();
            mode = ST_CSI;
          end else if (c < CH_ZERO || c > CH_NINE) begin
            store_arg();
            mode = ST_PLAIN;
            run_final(c, int'(x), int'(y));
          end else begin
            mode = ST_NUM;
            accum = accum * 10 + int'(c - CH_ZERO);
            if (accum > 65535) accum = 65535;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(acp_result_t got);
      acp_result_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        $error("command %0d arrived with nothing expected", got.command);
        errors++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        compare_field("command", 16'(exp_cmd.command), 16'(got.command));
        compare_field("char_code", 16'(exp_cmd.char_code), 16'(got.char_code));
        compare_field("fg_color", 16'(exp_cmd.fg_color), 16'(got.fg_color));
        compare_field("bg_color", 16'(exp_cmd.bg_color), 16'(got.bg_color));
        compare_field("new_x", exp_cmd.new_x, got.new_x);
        compare_field("new_y", exp_cmd.new_y, got.new_y);
        compare_field("direction", 16'(exp_cmd.direction), 16'(got.direction));
        compare_field("amount", exp_cmd.amount, got.amount);
      end
    endfunction

    function void report_leftover();
      if (pending_cmds.size() != 0) begin
        $error("%0d expected commands never arrived", pending_cmds.size());
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // byte_in [7:0], cursor_x [23:8], cursor_y [39:24]
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // command [2:0], char_code [10:3], fg_color [14:11], bg_color [18:15],
  // new_x [34:19], new_y [50:35], direction [52:51], amount [68:53]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_DEFAULT_FG;
  logic [3:0]            cfg_data  = '0;

  console_cmd_model cmd_model;
  bit               steady      = 1'b0;
  int               items_sent  = 0;
  int               idle_cycles = 0;

  ansi_csi_console_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      cmd_model.check_result(acp_result_t'(m_tdata));
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic [15:0] x,
                           input logic [15:0] y);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cmd_model.note_byte(c, x, y);
    items_sent++;
  endtask

  // ESC '[' then the parameter text, then the final byte.
  task automatic send_csi(input string params, input logic [7:0] fin,
                          input logic [15:0] x, input logic [15:0] y);
    send_byte(CH_ESC, x, y);
    send_byte(CH_LBRACKET, x, y);
    for (int i = 0; i < params.len(); i++) send_byte(params[i], x, y);
    send_byte(fin, x, y);
  endtask

  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (cmd_model.pending_cmds.size() != 0) @(posedge clk);
    // SGR walks and cursor saves finish without a result to wait for.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cmd_model.set_default(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hffff;
      3:       return 16'hfffe;
      4:       return 16'($urandom_range(0, 100));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_final();
    case ($urandom_range(0, 16))
      0:       return FIN_UP;
      1:       return FIN_DOWN;
      2:       return FIN_RIGHT;
      3:       return FIN_LEFT;
      4:       return FIN_NEXT;
      5:       return FIN_PREV;
      6:       return FIN_COLUMN;
      7:       return FIN_POS;
      8:       return FIN_POS_ALT;
      9:       return FIN_ERASE_S;
      10:      return FIN_ERASE_L;
      11:      return FIN_SCR_UP;
      12:      return FIN_SCR_DN;
      13:      return FIN_SAVE;
      14:      return FIN_RESTORE;
      15:      return FIN_UNUSED;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic string pick_arg(bit sgr);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 12) return "";
    if (sgr) begin
      case ($urandom_range(0, 6))
        0:       v = int'(SGR_RESET);
        1:       v = int'(SGR_BOLD);
        2:       v = int'(SGR_NO_BOLD);
        3:       v = $urandom_range(int'(SGR_FG_FIRST), int'(SGR_FG_LAST));
        4:       v = $urandom_range(0, 1) ? int'(SGR_FG_DEF) : int'(SGR_BG_DEF);
        5:       v = $urandom_range(int'(SGR_BG_FIRST), int'(SGR_BG_LAST));
        default: v = $urandom_range(0, 99);
      endcase
    end else if (r < 60) begin
      v = $urandom_range(0, 9);
    end else if (r < 85) begin
      v = $urandom_range(0, 200);
    end else if (r < 95) begin
      v = $urandom_range(0, 65535);
    end else begin
      v = $urandom_range(65536, 999999);
    end
    return $sformatf("%0d", v);
  endfunction

  // Mostly well-formed CSI sequences and plain text, with some broken escapes.
  task automatic send_random_burst();
    int          kind;
    int          n;
    bit          sgr;
    string       digits;
    logic [7:0]  fin;
    logic [15:0] x;
    logic [15:0] y;
    x = pick_coord();
    y = pick_coord();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), x, y);
    end else if (kind < 90) begin
      sgr = ($urandom_range(0, 2) == 0);
      fin = sgr ? FIN_SGR : pick_final();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 13) : $urandom_range(0, 3);
      send_byte(CH_ESC, x, y);
      send_byte(CH_LBRACKET, x, y);
      for (int i = 0; i < n; i++) begin
        if (i > 0) send_byte(CH_SEMI, x, y);
        digits = pick_arg(sgr);
        for (int k = 0; k < digits.len(); k++) send_byte(digits[k], x, y);
      end
      send_byte(fin, x, y);
    end else begin
      send_byte(CH_ESC, x, y);
      if ($urandom_range(0, 1)) begin
        send_byte(8'($urandom_range(0, 255)), x, y);
      end else begin
        send_byte(CH_LBRACKET, x, y);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), x, y);
      end
    end
  endtask

  initial begin
    logic [3:0] fg_set[5];
    logic [3:0] bg_set[5];
    int         target;
    fg_set = '{4'd15, 4'd0, 4'd15, 4'($urandom_range(0, 15)), 4'd0};
    bg_set = '{4'd15, 4'd0, 4'd0, 4'($urandom_range(0, 15)), 4'd15};
    cmd_model = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the color registers at their reset values.
    send_byte(8'h00, 16'd0, 16'd0);
    send_byte(8'hff, 16'hffff, 16'hffff);
    send_byte(CH_ESC, 16'd0, 16'd0);
    send_byte(FIN_UP, 16'd0, 16'd0);
    send_byte(CH_LBRACKET, 16'd3, 16'd4);
    send_csi("", FIN_UP, 16'd5, 16'd0);
    send_csi("9", FIN_UP, 16'd5, 16'd3);
    send_csi("", FIN_LEFT, 16'd0, 16'd7);
    send_csi("2", FIN_LEFT, 16'hffff, 16'd0);
    send_csi("99999", FIN_DOWN, 16'd0, 16'hffff);
    send_csi("0", FIN_RIGHT, 16'hfffe, 16'd1);
    send_csi("3", FIN_NEXT, 16'd9, 16'hfffe);
    send_csi("", FIN_PREV, 16'd9, 16'd0);
    send_csi("", FIN_COLUMN, 16'd9, 16'd2);
    send_csi("80", FIN_COLUMN, 16'd9, 16'd2);
    send_csi("5", FIN_POS, 16'd11, 16'd12);
    send_csi("5;0", FIN_POS_ALT, 16'd11, 16'd12);
    send_csi(";", FIN_POS, 16'd11, 16'd12);
    send_csi("12;40", FIN_POS, 16'd11, 16'd12);
    send_csi("", FIN_ERASE_S, 16'd1, 16'd1);
    send_csi("0", FIN_ERASE_S, 16'd1, 16'd1);
    send_csi("1", FIN_ERASE_L, 16'd1, 16'd1);
    send_csi("7", FIN_ERASE_L, 16'd1, 16'd1);
    send_csi("4", FIN_SCR_UP, 16'd1, 16'd1);
    send_csi("", FIN_SCR_DN, 16'd1, 16'd1);
    send_csi("", FIN_SAVE, 16'd123, 16'd456);
    send_csi("", FIN_RESTORE, 16'd0, 16'd0);
    send_csi("1;31;42", FIN_SGR, 16'd0, 16'd0);
    send_byte(8'h61, 16'd0, 16'd0);
    send_csi("1;39;49", FIN_SGR, 16'd0, 16'd0);
    send_byte(8'h62, 16'd0, 16'd0);
    send_csi("22;30;40", FIN_SGR, 16'd0, 16'd0);
    send_byte(8'h63, 16'd0, 16'd0);
    // Arguments past the tenth are dropped, so the colors stay put.
    send_csi("1;2;3;4;5;6;7;8;9;10;33;44", FIN_SGR, 16'd0, 16'd0);
    send_byte(8'h64, 16'd0, 16'd0);
    send_csi("0", FIN_SGR, 16'd0, 16'd0);
    send_csi("1;2", FIN_UNUSED, 16'd0, 16'd0);
    send_byte(8'h65, 16'd0, 16'd0);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_cfg(CFG_DEFAULT_FG, fg_set[p]);
      write_cfg(CFG_DEFAULT_BG, bg_set[p]);
      steady = (p == 2);
      target = items_sent + PHASE_ITEMS;
      // Bring the new defaults into use before the random stream.
      send_csi("0;1", FIN_SGR, 16'd0, 16'd0);
      send_byte(8'h66, 16'd0, 16'd0);
      while (items_sent < target) send_random_burst();
    end

    steady = 1'b0;
    settle();
    cmd_model.report_leftover();
    if (cmd_model.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
